[rtl/core/invariant_divider_datapath_assert.svh]
// Assertion macros shared by the invariant divider datapath RTL.
// Define ASSERT_OFF to compile every assertion out; no other dependencies.
`ifndef INVARIANT_DIVIDER_DATAPATH_ASSERT_SVH
`define INVARIANT_DIVIDER_DATAPATH_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define IDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idd assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define IDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idd assertion failed: next-cycle implication");

`else

`define IDD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/idd_pkg.sv]
// Shared types, codes and helper functions for the invariant divider datapath.
// No dependencies; imported by every module of the block.
package idd_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int EXT_W     = 48;

    typedef enum logic [2:0] {
        M_USHIFT       = 3'd0,
        M_UMULHI       = 3'd1,
        M_UAVG         = 3'd2,
        M_UAVG_RND     = 3'd3,
        M_SFLOOR_SHIFT = 3'd4,
        M_SFLOOR_XOR   = 3'd5,
        M_STRUNC_BIAS  = 3'd6,
        M_STRUNC_MULHI = 3'd7
    } method_t;

    typedef enum logic [1:0] {
        REG_METHOD     = 2'd0,
        REG_MULTIPLIER = 2'd1,
        REG_POST_SHIFT = 2'd2,
        REG_WIDTH_SEL  = 2'd3
    } reg_index_t;

    typedef struct packed {
        method_t             method;
        logic [DATA_W-1:0]   multiplier;
        logic [3:0]          post_shift;
        logic [1:0]          width_select;
    } cfg_t;

    // Stage 1: decoded numerator, multiplier operand, shift-only result.
    typedef struct packed {
        logic [DATA_W-1:0]   n;
        logic                neg;
        logic [DATA_W-1:0]   opnd;
        logic [DATA_W-1:0]   q_simple;
        logic                err;
    } st1_t;

    // Stage 2: full product.
    typedef struct packed {
        logic [DATA_W-1:0]   n;
        logic                neg;
        logic [PROD_W-1:0]   prod;
        logic [DATA_W-1:0]   q_simple;
        logic                err;
    } st2_t;

    // Stage 3: value ready for the final shift.
    typedef struct packed {
        logic [PROD_W-1:0]   val;
        logic                neg;
        logic [DATA_W-1:0]   q_simple;
        logic                err;
    } st3_t;

    function automatic logic [5:0] width_of(input logic [1:0] sel);
        logic [5:0] w;
        case (sel)
            2'd0:    w = 6'd8;
            2'd1:    w = 6'd16;
            default: w = 6'd32;
        endcase
        if (w > 6'(MAX_WIDTH))
            w = 6'(MAX_WIDTH);
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] mask_of(input logic [1:0] sel);
        logic [DATA_W:0] m;
        m = ((DATA_W+1)'(1) << width_of(sel)) - (DATA_W+1)'(1);
        return m[DATA_W-1:0];
    endfunction

endpackage

[rtl/core/idd_front.sv]
// Stage 1 of the invariant divider: decode the numerator at the selected width.
// Depends on idd_pkg.
module idd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  idd_pkg::cfg_t                 cfg,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [idd_pkg::DATA_W-1:0]    numerator,
    output logic                          valid,
    output idd_pkg::st1_t                 st
);
    import idd_pkg::*;

    logic [5:0]        wlen;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] n;
    logic              neg;
    logic [EXT_W-1:0]  nsx;
    logic [EXT_W-1:0]  bias;
    logic [EXT_W-1:0]  biased;
    logic [EXT_W-1:0]  sh_plain;
    logic [EXT_W-1:0]  sh_bias;
    logic              big_mult;
    st1_t              st_next;
    st1_t              st_reg;
    logic              valid_reg;

    always_comb
    begin
        wlen     = width_of(cfg.width_select);
        mask     = mask_of(cfg.width_select);
        n        = numerator & mask;
        neg      = n[5'(wlen - 6'd1)];
        nsx      = neg ? {{(EXT_W-DATA_W){1'b1}}, n | ~mask} : {{(EXT_W-DATA_W){1'b0}}, n};
        bias     = (EXT_W'(1) << cfg.post_shift) - EXT_W'(1);
        biased   = nsx + (neg ? bias : '0);
        sh_plain = EXT_W'($signed(nsx) >>> cfg.post_shift);
        sh_bias  = EXT_W'($signed(biased) >>> cfg.post_shift);
        big_mult = |(cfg.multiplier & ~mask);

        st_next.n        = n;
        st_next.neg      = neg;
        st_next.opnd     = n;
        st_next.q_simple = n >> cfg.post_shift;
        st_next.err      = 1'b0;
        case (cfg.method)
            M_USHIFT:
            begin
                st_next.q_simple = n >> cfg.post_shift;
            end
            M_UMULHI, M_UAVG, M_UAVG_RND:
            begin
                st_next.err = big_mult;
            end
            M_SFLOOR_SHIFT:
            begin
                st_next.q_simple = sh_plain[DATA_W-1:0];
            end
            M_SFLOOR_XOR:
            begin
                st_next.opnd = neg ? (~n & mask) : n;
                st_next.err  = big_mult;
            end
            M_STRUNC_BIAS:
            begin
                st_next.q_simple = sh_bias[DATA_W-1:0];
            end
            M_STRUNC_MULHI:
            begin
                // magnitude of a negative value fits: at most half the range
                st_next.opnd = neg ? ((~n + DATA_W'(1)) & mask) : n;
                st_next.err  = big_mult;
            end
            default:
            begin
                st_next.err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            st_reg <= st_next;
    end

    assign valid = valid_reg;
    assign st    = st_reg;

endmodule

[rtl/core/idd_mul.sv]
// Stage 2 of the invariant divider: 32x32 unsigned multiply, registered.
// Depends on idd_pkg.
module idd_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  idd_pkg::cfg_t cfg,
    input  logic          en,
    input  logic          in_valid,
    input  idd_pkg::st1_t st_in,
    output logic          valid,
    output idd_pkg::st2_t st
);
    import idd_pkg::*;

    st2_t st_next;
    st2_t st_reg;
    logic valid_reg;

    always_comb
    begin
        st_next.n        = st_in.n;
        st_next.neg      = st_in.neg;
        st_next.prod     = PROD_W'(st_in.opnd) * PROD_W'(cfg.multiplier);
        st_next.q_simple = st_in.q_simple;
        st_next.err      = st_in.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            st_reg <= st_next;
    end

    assign valid = valid_reg;
    assign st    = st_reg;

endmodule

[rtl/core/idd_back.sv]
// Stages 3 and 4 of the invariant divider: high-part add or negate, then the
// final shift, sign fix-up and width mask into the output register. Depends on idd_pkg.
module idd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  idd_pkg::cfg_t               cfg,
    input  logic                        en3,
    input  logic                        en4,
    input  logic                        in_valid,
    input  idd_pkg::st2_t               st_in,
    output logic                        valid3,
    output logic                        valid4,
    output logic [idd_pkg::DATA_W-1:0]  quotient,
    output logic                        range_error
);
    import idd_pkg::*;

    logic [5:0]        wlen;
    logic [PROD_W-1:0] hi;
    st3_t              st3_next;
    st3_t              st3_reg;
    logic              valid3_reg;

    logic [5:0]        k;
    logic [PROD_W-1:0] shr_l;
    logic [PROD_W-1:0] shr_a;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] quot_next;
    logic [DATA_W-1:0] quot_reg;
    logic              err_reg;
    logic              valid4_reg;

    // Stage 3: form the value that the last shift works on.
    always_comb
    begin
        wlen              = width_of(cfg.width_select);
        hi                = st_in.prod >> wlen;
        st3_next.neg      = st_in.neg;
        st3_next.q_simple = st_in.q_simple;
        st3_next.err      = st_in.err;
        case (cfg.method)
            M_UAVG:         st3_next.val = hi + PROD_W'(st_in.n);
            M_UAVG_RND:     st3_next.val = hi + PROD_W'(st_in.n) + PROD_W'(1);
            M_SFLOOR_XOR:   st3_next.val = st_in.prod;
            M_STRUNC_MULHI: st3_next.val = st_in.neg ? (~st_in.prod + PROD_W'(1)) : st_in.prod;
            default:        st3_next.val = hi;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid3_reg <= 1'b0;
        else if (en3)
            valid3_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
            st3_reg <= st3_next;
    end

    // Stage 4: shift, fix the sign, cut to width.
    always_comb
    begin
        case (cfg.method)
            M_UAVG, M_UAVG_RND:           k = 6'(cfg.post_shift) + 6'd1;
            M_SFLOOR_XOR, M_STRUNC_MULHI: k = wlen + 6'(cfg.post_shift);
            default:                      k = 6'(cfg.post_shift);
        endcase
        shr_l = st3_reg.val >> k;
        shr_a = PROD_W'($signed(st3_reg.val) >>> k);
        case (cfg.method)
            M_UMULHI, M_UAVG, M_UAVG_RND:
                q = shr_l[DATA_W-1:0];
            M_SFLOOR_XOR:
                q = st3_reg.neg ? ~shr_l[DATA_W-1:0] : shr_l[DATA_W-1:0];
            M_STRUNC_MULHI:
                q = shr_a[DATA_W-1:0] + DATA_W'(st3_reg.neg);
            default:
                q = st3_reg.q_simple;
        endcase
        quot_next = q & mask_of(cfg.width_select);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid4_reg <= 1'b0;
        else if (en4)
            valid4_reg <= valid3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4 && valid3_reg)
        begin
            quot_reg <= quot_next;
            err_reg  <= st3_reg.err;
        end
    end

    assign valid3      = valid3_reg;
    assign valid4      = valid4_reg;
    assign quotient    = quot_reg;
    assign range_error = err_reg;

endmodule

[rtl/core/invariant_divider_datapath.sv]
// Invariant divider datapath: divides each numerator by a software-chosen constant
// with a configured magic multiplier and post shift. Depends on idd_pkg, idd_front,
// idd_mul, idd_back and invariant_divider_datapath_assert.svh.
//
// Usage:
//   - Slave stream s_axis_*: one numerator per transaction (low W bits used).
//   - Master stream m_axis_*: one quotient per transaction, zero-extended from W
//     bits; tuser flags a multiplier wider than W bits for the multiplying methods.
//   - Config port cfg_*: write method, multiplier, post_shift, width_select while
//     no transaction is in flight; writes take effect at the next clock edge.
//   - Four register stages: decode, 32x32 multiply, add/negate, shift and mask.
//   - Throughput: one transaction per cycle while m_axis_tready is high; the
//     multiplier stage is fully pipelined.
//   - Each stage advances when it is empty or the stage after it advances, so
//     bubbles collapse and a stalled receiver holds the result in the output
//     register while upstream stages keep filling; s_axis_tready drops only
//     when all four stages hold data and m_axis_tready is low.
//   - Reset: clears all stage valids and loads method 0, multiplier 0,
//     post_shift 0 and width_select 2 (32 bits).
module invariant_divider_datapath (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // [31:0] numerator
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,     // [31:0] quotient
    output logic        m_axis_tuser      // [0] range_error
);
    import idd_pkg::*;

`include "invariant_divider_datapath_assert.svh"

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic en1, en2, en3, en4;
    logic v1, v2, v3, v4;
    st1_t st1;
    st2_t st2;

    // Config registers: update on write enable, ignore nothing else.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_METHOD:     cfg_next.method       = method_t'(cfg_data[2:0]);
                REG_MULTIPLIER: cfg_next.multiplier   = cfg_data;
                REG_POST_SHIFT: cfg_next.post_shift   = cfg_data[3:0];
                REG_WIDTH_SEL:  cfg_next.width_select = cfg_data[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method       <= M_USHIFT;
            cfg_reg.multiplier   <= '0;
            cfg_reg.post_shift   <= '0;
            cfg_reg.width_select <= 2'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage enables: advance when empty or when the next stage advances.
    assign en4 = !v4 || m_axis_tready;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    assign s_axis_tready = en1;

    idd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .en        (en1),
        .in_valid  (s_axis_tvalid),
        .numerator (s_axis_tdata),
        .valid     (v1),
        .st        (st1)
    );

    idd_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .en       (en2),
        .in_valid (v1),
        .st_in    (st1),
        .valid    (v2),
        .st       (st2)
    );

    idd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .en3         (en3),
        .en4         (en4),
        .in_valid    (v2),
        .st_in       (st2),
        .valid3      (v3),
        .valid4      (v4),
        .quotient    (m_axis_tdata),
        .range_error (m_axis_tuser)
    );

    assign m_axis_tvalid = v4;

    // An accepted transaction always lands in the first stage.
    `IDD_ASSERT_NEXT(a_accept_lands, clk, rst_n, s_axis_tvalid && s_axis_tready, v1)
    // A full stage 3 moving on always fills the output register.
    `IDD_ASSERT_NEXT(a_stage3_moves, clk, rst_n, v3 && en4, v4)
    // Backpressure reaches the input only when every stage is occupied.
    `IDD_ASSERT_IMPL(a_full_blocks, clk, rst_n, !s_axis_tready, v1 && v2 && v3 && v4 && !m_axis_tready)
    // A stalled stage 2 keeps its item until stage 3 frees up.
    `IDD_ASSERT_NEXT(a_stage2_holds, clk, rst_n, v2 && !en3, v2)

endmodule
